@@ rtl/core/flptm_pkg.sv @@
// ----------------------------------------------------------------------------
// flptm_pkg
// Shared types, field widths and codes for the four-level page table mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package flptm_pkg;

    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int FLAG_W     = 12;
    localparam int PN_W       = PA_W - FLAG_W;
    localparam int ENTRY_W    = PA_W;
    localparam int IDX_W      = 9;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 52;

    localparam logic [1:0]        PRESENT_BITS = 2'b11;
    localparam logic [FLAG_W-1:0] FLAGS_RESET  = 12'h003;
    localparam logic [CNT_W-1:0]  LIMIT_RESET  = 11'd16;
    localparam logic [CNT_W-1:0]  NFF_RESET    = 11'd1;

    localparam logic [1:0] LEVEL_ROOT = 2'd0;
    localparam logic [1:0] LEVEL_LAST = 2'd2;
    localparam logic [1:0] LEVEL_LEAF = 2'd3;

    typedef struct packed {
        logic [VA_W-1:0] virtual_address;
        logic [PA_W-1:0] physical_address;
        logic            last_page;
    } in_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] leaf_entry;
        logic [1:0]         tables_allocated;
        logic               error_code;
        logic               last_page_out;
    } out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_FLAGS  = 2'd0,
        CFG_POOL_BASE   = 2'd1,
        CFG_FRAME_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_FOLLOW,
        OP_ADVANCE,
        OP_NEED,
        OP_CHECK,
        OP_LINK,
        OP_READ,
        OP_LEAF
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       present;
        logic [1:0] level;
        logic       err;
        logic       clr_last;
        logic       out_busy;
    } status_t;

    // table index for one walk level
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] level);
        logic [IDX_W-1:0] idx;
        case (level)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/flptm_ram.sv @@
// ----------------------------------------------------------------------------
// flptm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module flptm_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 8192,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/flptm_ctrl.sv @@
// ----------------------------------------------------------------------------
// flptm_ctrl
// Walk sequencer: clearing pass, dry walk, frame check, allocating walk.
// ----------------------------------------------------------------------------
`default_nettype none

module flptm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire flptm_pkg::status_t status,
    output flptm_pkg::cmd_t        cmd
);
    import flptm_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRY,
        ST_CHECK,
        ST_LINK,
        ST_READ,
        ST_REAL,
        ST_LEAF,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_START;
                    state_next = ST_DRY;
                end
            end
            ST_DRY: begin
                if (!status.present) begin
                    cmd.op     = OP_NEED;
                    state_next = ST_CHECK;
                end else if (status.level == LEVEL_LAST) begin
                    cmd.op     = OP_ADVANCE;
                    state_next = ST_CHECK;
                end else begin
                    cmd.op = OP_FOLLOW;
                end
            end
            ST_CHECK: begin
                cmd.op = OP_CHECK;
                if (status.err) begin
                    state_next = ST_HOLD;
                end else if (status.level == LEVEL_LEAF) begin
                    state_next = ST_LEAF;
                end else begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                cmd.op     = OP_LINK;
                state_next = (status.level == LEVEL_LAST) ? ST_LEAF : ST_READ;
            end
            ST_READ: begin
                cmd.op     = OP_READ;
                state_next = ST_REAL;
            end
            ST_REAL: begin
                if (!status.present) begin
                    cmd.op     = OP_LINK;
                    state_next = (status.level == LEVEL_LAST) ? ST_LEAF : ST_READ;
                end else if (status.level == LEVEL_LAST) begin
                    cmd.op     = OP_ADVANCE;
                    state_next = ST_LEAF;
                end else begin
                    cmd.op = OP_FOLLOW;
                end
            end
            ST_LEAF: begin
                cmd.op       = OP_LEAF;
                cmd.out_load = !status.out_busy;
                state_next   = status.out_busy ? ST_HOLD : ST_IDLE;
            end
            ST_HOLD: begin
                cmd.out_load = !status.out_busy;
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/flptm_dpath.sv @@
// ----------------------------------------------------------------------------
// flptm_dpath
// Table store, walk registers, frame allocator, config and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flptm_dpath #(
    parameter int TABLE_FRAMES = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire flptm_pkg::cmd_t                      cmd,
    output flptm_pkg::status_t                        status,
    input  wire flptm_pkg::in_t                       s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output flptm_pkg::out_t                           m_data,
    input  wire logic                                 cfg_we,
    input  wire logic [flptm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [flptm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import flptm_pkg::*;

    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int DEPTH = TABLE_FRAMES * 512;
    localparam int AW    = FW + IDX_W;
    localparam logic [CNT_W-1:0] FRAMES_CNT = CNT_W'(TABLE_FRAMES);
    localparam logic [PN_W-1:0]  FRAMES_PN  = PN_W'(TABLE_FRAMES);
    localparam logic [AW-1:0]    CLR_LAST   = AW'(DEPTH - 1);

    // request payload
    logic [VA_W-1:0]   va_reg;
    logic [PA_W-1:0]   pa_reg;
    logic              last_reg;

    // walk state
    logic [FW-1:0]     cur_frame_reg;
    logic [1:0]        level_reg;
    logic [1:0]        need_reg;
    logic              err_reg;
    logic [CNT_W-1:0]  nff_reg;
    logic [AW-1:0]     clr_cnt_reg;

    // config
    logic [FLAG_W-1:0] flags_reg;
    logic [PN_W-1:0]   base_reg;
    logic [CNT_W-1:0]  limit_reg;

    // result
    logic              m_valid_reg;
    out_t              m_data_reg;

    logic              ram_en, ram_we;
    logic [AW-1:0]     ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic [PN_W-1:0]   off;
    logic              present;
    logic [FW-1:0]     follow_frame;
    logic [CNT_W-1:0]  lim, left;
    logic              err;
    logic [ENTRY_W-1:0] link_entry, leaf_entry;

    flptm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // link decode, relative to the current pool base
    always_comb begin
        off          = ram_rdata[ENTRY_W-1:FLAG_W] - base_reg;
        present      = (ram_rdata[1:0] == PRESENT_BITS) && (off < FRAMES_PN);
        follow_frame = off[FW-1:0];
    end

    // frames remaining against the request's need
    always_comb begin
        lim  = (limit_reg > FRAMES_CNT) ? FRAMES_CNT : limit_reg;
        left = (lim > nff_reg) ? (lim - nff_reg) : '0;
        err  = (CNT_W'(need_reg) > left);
    end

    assign link_entry = {base_reg + PN_W'(nff_reg), flags_reg};
    assign leaf_entry = {pa_reg[PA_W-1:FLAG_W], flags_reg};

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = {cur_frame_reg, level_index(va_reg, level_reg)};
        ram_wdata = '0;
        case (cmd.op)
            OP_CLEAR: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
            end
            OP_START: begin
                ram_en   = 1'b1;
                ram_addr = {FW'(0), level_index(s_data.virtual_address, LEVEL_ROOT)};
            end
            OP_FOLLOW: begin
                ram_en   = 1'b1;
                ram_addr = {follow_frame, level_index(va_reg, level_reg + 2'd1)};
            end
            OP_READ: begin
                ram_en = 1'b1;
            end
            OP_LINK: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = link_entry;
            end
            OP_LEAF: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = leaf_entry;
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_frame_reg <= '0;
            level_reg     <= LEVEL_ROOT;
            need_reg      <= '0;
            err_reg       <= 1'b0;
            nff_reg       <= NFF_RESET;
            clr_cnt_reg   <= '0;
            flags_reg     <= FLAGS_RESET;
            base_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            case (cmd.op)
                OP_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
                OP_START: begin
                    cur_frame_reg <= '0;
                    level_reg     <= LEVEL_ROOT;
                    need_reg      <= '0;
                end
                OP_FOLLOW, OP_ADVANCE: begin
                    cur_frame_reg <= follow_frame;
                    level_reg     <= level_reg + 2'd1;
                end
                OP_NEED: begin
                    need_reg <= LEVEL_LEAF - level_reg;
                end
                OP_CHECK: begin
                    err_reg <= err;
                end
                OP_LINK: begin
                    cur_frame_reg <= nff_reg[FW-1:0];
                    nff_reg       <= nff_reg + CNT_W'(1);
                    level_reg     <= level_reg + 2'd1;
                end
                default: begin
                    level_reg <= level_reg;
                end
            endcase

            if (cfg_we) begin
                case (cfg_index)
                    CFG_PAGE_FLAGS:  flags_reg <= cfg_data[FLAG_W-1:0];
                    CFG_POOL_BASE:   base_reg  <= cfg_data[PA_W-1:FLAG_W];
                    CFG_FRAME_LIMIT: limit_reg <= cfg_data[CNT_W-1:0];
                    default:         flags_reg <= flags_reg;
                endcase
            end

            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_START) begin
            va_reg   <= s_data.virtual_address;
            pa_reg   <= s_data.physical_address;
            last_reg <= s_data.last_page;
        end
        if (cmd.out_load) begin
            if (err_reg) begin
                m_data_reg <= '{leaf_entry: '0, tables_allocated: 2'd0,
                                error_code: 1'b1, last_page_out: last_reg};
            end else begin
                m_data_reg <= '{leaf_entry: leaf_entry, tables_allocated: need_reg,
                                error_code: 1'b0, last_page_out: last_reg};
            end
        end
    end

    always_comb begin
        status.present  = present;
        status.level    = level_reg;
        status.err      = err;
        status.clr_last = (clr_cnt_reg == CLR_LAST);
        status.out_busy = m_valid_reg && !m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/four_level_page_table_mapper_core.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_core
// Maps one 4 KiB page per request into a four-level tree of 512-entry tables.
//
// s_ channel: one map request per transfer (virtual address, physical address,
// last-page mark). m_ channel: one result per request (leaf entry written,
// new tables taken, out-of-frames error, last-page copy). cfg_ channel:
// register writes, always ready, meant for use while the block is idle.
// After reset the table store is swept to zero, one entry a cycle, through all
// TABLE_FRAMES*512 entries (8192 at the default); s_ready stays low meanwhile,
// config transfers are still taken.
// The walk runs through the single table store port: a fully present path
// takes three dependent reads, a frame check and the leaf write, each new
// level is linked by a write, an out of frames error returns after the dry
// walk. The next request is taken only after the result is loaded, so the
// block holds one walk at a time.
// A stalled receiver holds the result register; one request can finish its
// walk behind it and waits before the result load until m_ready frees it.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_mapper_core #(
    parameter int TABLE_FRAMES = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // map requests
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire flptm_pkg::in_t                   s_data,
    // results
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output flptm_pkg::out_t                       m_data,
    // register writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [flptm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [flptm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import flptm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // config writes go straight into the registers, no back-pressure
    assign cfg_ready = 1'b1;

    // sequencer: clearing pass, dry walk, check, allocating walk, result load
    flptm_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    // table store, allocator, config and result register
    flptm_dpath #(
        .TABLE_FRAMES(TABLE_FRAMES)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

`ifndef ASSERT_OFF
    // one request at a time: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while a walk is under way");

    // a result is never loaded over one the receiver has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid && !m_ready))
        else $error("result register overwritten");

    // a loaded result is offered in the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not offered");

    // no new request during the clearing pass or a walk with a result pending
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_START) |-> s_ready)
        else $error("walk started outside idle");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-level page table mapper core. Map requests
// go in over the s_ channel in random bursts while the result channel stalls
// on its own pattern. An in-bench copy of the table store and allocator
// predicts each result. Directed requests cover out of frames, flags lacking
// the present bits, base moves and address wrap. Random phases then reuse the
// mapped prefixes under changing register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import flptm_pkg::*;

    localparam int TABLE_FRAMES    = 16;
    localparam int STORE_DEPTH     = TABLE_FRAMES * 512;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 30000;   // longer than the clear sweep
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 200;
    localparam int REPORT_LIMIT    = 10;
    localparam logic [51:0] ALL_ONES52 = 52'hF_FFFF_FFFF_FFFF;
    localparam logic [51:0] FAR_BASE   = 52'h8_0000_0000_0000;

    typedef enum int {RX_OPEN, RX_SKIP, RX_COIN, RX_BURSTY} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // requests waiting to be driven, results waiting to arrive
    in_t               map_requests[$];
    out_t              awaited_results[$];
    // upper three walk indices (va[47:21]) of paths the directed part built
    logic [26:0]       known_prefixes[$];

    // bench copy of the block's state and registers
    logic [51:0]       table_copy[STORE_DEPTH];
    logic [10:0]       next_free_copy;
    logic [11:0]       flags_copy;
    logic [51:0]       pool_base_copy;
    logic [10:0]       limit_copy;

    int                fail_count;
    int                idle_cycles;
    int                burst_left;
    int                gap_left;
    int                rx_cycle;
    rx_mode_t          rx_mode;
    logic              ready_next;
    out_t              want;

    four_level_page_table_mapper_core #(
        .TABLE_FRAMES(TABLE_FRAMES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // 9-bit table index of one walk level, root first
    function automatic int unsigned walk_index(input logic [47:0] va, input int lvl);
        logic [47:0] shifted;
        shifted = va >> (39 - 9 * lvl);
        return 32'(shifted[8:0]);
    endfunction

    // a link is usable when both present bits are set and it lands inside the pool
    function automatic bit link_target(input logic [51:0] entry, output int unsigned frame);
        logic [51:0] off;
        off = {entry[51:12], 12'h000} - pool_base_copy;
        frame = off[43:12];
        return (entry[1:0] == 2'b11) && (off[51:12] < 40'(TABLE_FRAMES));
    endfunction

    // walks the bench table copy, allocates and writes, returns the result
    function automatic out_t predict_mapping(input in_t req);
        logic [47:0] va;
        logic [51:0] leaf;
        int unsigned frame, nf, need, lim, avail, slot;
        out_t res;
        va = req.virtual_address;
        res = '0;
        res.last_page_out = req.last_page;
        // dry walk: count missing levels
        frame = 0;
        need = 0;
        for (int lvl = 0; lvl < 3 && need == 0; lvl++) begin
            slot = frame * 512 + walk_index(va, lvl);
            if (!link_target(table_copy[slot], nf)) begin
                need = 3 - lvl;
            end else begin
                frame = nf;
            end
        end
        lim = (32'(limit_copy) > TABLE_FRAMES) ? TABLE_FRAMES : 32'(limit_copy);
        avail = (lim > 32'(next_free_copy)) ? lim - 32'(next_free_copy) : 0;
        if (need > avail) begin
            res.error_code = 1'b1;
            return res;
        end
        // real walk, linking new frames from the bump allocator
        frame = 0;
        for (int lvl = 0; lvl < 3; lvl++) begin
            slot = frame * 512 + walk_index(va, lvl);
            if (!link_target(table_copy[slot], nf)) begin
                nf = 32'(next_free_copy);
                next_free_copy = next_free_copy + 11'd1;
                table_copy[slot] = (pool_base_copy + ({20'd0, nf} << 12))
                                   | {40'd0, flags_copy};
            end
            frame = nf;
        end
        leaf = {req.physical_address[51:12], 12'h000} | {40'd0, flags_copy};
        table_copy[frame * 512 + walk_index(va, 3)] = leaf;
        res.leaf_entry = leaf;
        res.tables_allocated = need[1:0];
        return res;
    endfunction

    // register write through the cfg channel, mirrored into the bench copy
    task automatic write_reg(input cfg_idx_t idx, input logic [51:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_PAGE_FLAGS:  flags_copy = value[11:0];
            CFG_POOL_BASE:   pool_base_copy = {value[51:12], 12'h000};
            CFG_FRAME_LIMIT: limit_copy = value[10:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // hold off until the block has nothing in flight, then let the walk settle
    task automatic drain();
        while (map_requests.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // directed request; its prefix feeds the random part
    task automatic queue_map(input logic [47:0] va, input logic [51:0] pa, input logic last);
        in_t req;
        req.virtual_address = va;
        req.physical_address = pa;
        req.last_page = last;
        map_requests.push_back(req);
        known_prefixes.push_back(va[47:21]);
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of transfers with random gaps, one valid update per edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            // accepted request: predict now, while the bench state is in order
            if (s_valid && s_ready)
                awaited_results.push_back(predict_mapping(s_data));
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || map_requests.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data <= map_requests.pop_front();
                    if (burst_left == 0) begin
                        // mostly short bursts, now and then a long unbroken run
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                   : $urandom_range(1, 40);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        case ($urandom_range(0, 9))
                            0:       gap_left = 0;
                            1, 2:    gap_left = $urandom_range(4, 20);
                            default: gap_left = $urandom_range(1, 3);
                        endcase
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check each result transfer against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: leaf=%h alloc=%0d err=%0d last=%0d",
                             m_data.leaf_entry, m_data.tables_allocated,
                             m_data.error_code, m_data.last_page_out);
            end else begin
                want = awaited_results.pop_front();
                if (m_data.leaf_entry !== want.leaf_entry
                    || m_data.tables_allocated !== want.tables_allocated
                    || m_data.error_code !== want.error_code
                    || m_data.last_page_out !== want.last_page_out) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $write("mismatch: expected leaf=%h alloc=%0d err=%0d last=%0d, ",
                               want.leaf_entry, want.tables_allocated, want.error_code,
                               want.last_page_out);
                        $display("got leaf=%h alloc=%0d err=%0d last=%0d",
                                 m_data.leaf_entry, m_data.tables_allocated,
                                 m_data.error_code, m_data.last_page_out);
                    end
                end
            end
        end
        // receiver backpressure, switching at random among four patterns
        rx_cycle++;
        if (rx_cycle % 50 == 0)
            rx_mode = rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:  ready_next = 1'b1;
            RX_SKIP:  ready_next = (rx_cycle % 4) != 0;
            RX_COIN:  ready_next = 1'($urandom_range(0, 1));
            default:  ready_next = (rx_cycle % 32) >= 24;
        endcase
        m_ready <= ready_next;
    end

    // progress counter: any transfer on any channel clears it
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog: covers the clear sweep after reset plus worst stalls
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("watchdog expired with %0d results outstanding", awaited_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        in_t         req;
        int          sel;
        int          lvl;
        logic [47:0] va;
        logic [51:0] pa;
        logic [11:0] flag_val;
        logic [51:0] base_val;
        logic [51:0] limit_val;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        rx_cycle = 0;
        rx_mode = RX_OPEN;
        for (int i = 0; i < STORE_DEPTH; i++)
            table_copy[i] = '0;
        next_free_copy = 11'd1;
        flags_copy = 12'h003;
        pool_base_copy = '0;
        limit_copy = 11'd16;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // all flags set, base one page below zero so links wrap, no frames left
        write_reg(CFG_PAGE_FLAGS, 52'hFFF);
        write_reg(CFG_POOL_BASE, ALL_ONES52);
        write_reg(CFG_FRAME_LIMIT, 52'd1);
        queue_map(48'h0, 52'h0, 1'b0);
        queue_map(48'hFFFF_FFFF_FFFF, ALL_ONES52, 1'b1);
        drain();

        // limit above the pool size: fresh trees, partial trees, leaf rewrite
        write_reg(CFG_FRAME_LIMIT, 52'd1024);
        queue_map(48'h0, ALL_ONES52, 1'b1);
        queue_map(48'hFFFF_FFFF_FFFF, 52'h0, 1'b0);
        queue_map(48'h0000_0000_1000, 52'h1_2345_6789_A000, 1'b0);
        queue_map(48'h0000_0020_0000, 52'h0_0000_0000_1FFF, 1'b0);
        queue_map(48'h0000_4000_0000, 52'hA_5A5A_5A5A_5555, 1'b1);
        queue_map(48'h0, 52'h1_2345_6789_ABCD, 1'b0);
        drain();

        // flags without both present bits: the same path allocates again,
        // then the pool runs dry exactly
        write_reg(CFG_PAGE_FLAGS, 52'h001);
        queue_map(48'h0080_0000_0000, 52'h5_5555_5555_5000, 1'b0);
        queue_map(48'h0080_0000_0000, 52'h2_AAAA_AAAA_A000, 1'b0);
        queue_map(48'h0080_0000_0000, 52'h3_3333_3333_3000, 1'b1);
        drain();
        write_reg(CFG_PAGE_FLAGS, 52'h000);
        queue_map(48'h0000_0000_1000, 52'hF_0F0F_0F0F_0F0F, 1'b0);
        drain();

        // base moved by one page: every old link now names the frame before it
        write_reg(CFG_PAGE_FLAGS, 52'h003);
        write_reg(CFG_POOL_BASE, 52'h0);
        queue_map(48'h0, 52'h7_7777_7777_7000, 1'b0);
        queue_map(48'hFFFF_FFFF_FFFF, 52'h8_8888_8888_8000, 1'b1);
        drain();

        // base far away: every link falls outside the pool
        write_reg(CFG_POOL_BASE, FAR_BASE);
        queue_map(48'h0000_0000_2000, 52'h9_9999_9999_9000, 1'b0);
        drain();

        // random phases: mostly walks down known paths, some with one index
        // broken, some fully random addresses
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0:       flag_val = 12'h003;
                1:       flag_val = 12'hFFF;
                2:       flag_val = {10'($urandom_range(0, 1023)), 2'b11};
                default: flag_val = 12'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 5))
                0:       base_val = 52'h0;
                1:       base_val = 52'({$urandom, $urandom});
                default: base_val = ALL_ONES52;
            endcase
            case (phase % 4)
                0:       limit_val = 52'd16;
                1:       limit_val = 52'd1;
                2:       limit_val = 52'd1024;
                default: limit_val = 52'($urandom_range(1, 1024));
            endcase
            write_reg(CFG_PAGE_FLAGS, {40'd0, flag_val});
            write_reg(CFG_POOL_BASE, base_val);
            write_reg(CFG_FRAME_LIMIT, limit_val);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 99);
                va = 48'({$urandom, $urandom});
                if (sel < 90)
                    va[47:21] = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
                if (sel >= 75 && sel < 90) begin
                    lvl = $urandom_range(0, 2);
                    va[47 - 9 * lvl -: 9] = 9'($urandom);
                end
                case ($urandom_range(0, 19))
                    0:       pa = 52'h0;
                    1:       pa = ALL_ONES52;
                    default: pa = 52'({$urandom, $urandom});
                endcase
                req.virtual_address = va;
                req.physical_address = pa;
                req.last_page = ($urandom_range(0, 7) == 0);
                map_requests.push_back(req);
            end
            // sender waits for every outstanding result before the next setting
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

@@ four_level_page_table_mapper_core.f @@
rtl/core/flptm_pkg.sv
rtl/core/flptm_ram.sv
rtl/core/flptm_ctrl.sv
rtl/core/flptm_dpath.sv
rtl/core/four_level_page_table_mapper_core.sv
test/tb.sv
